>>> src/tcspq_pkg.sv
// Shared types and constants for the two-class strict-priority queue scheduler.
// Used by tcspq_ctrl, tcspq_datapath and the top level; no dependencies.
package tcspq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TURN_W      = 16;
    localparam int TAG_W       = 32;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;

    // kind: bit 1 set means serve, else bit 0 picks the class (0 priority, 1 normal)
    localparam int KIND_SERVE_BIT = 1;
    localparam int KIND_CLASS_BIT = 0;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED    = 3'd0,
        ST_SERVED_PRIO = 3'd1,
        ST_SERVED_NORM = 3'd2,
        ST_EMPTY       = 3'd3,
        ST_FULL        = 3'd4
    } status_t;

    typedef struct packed {
        logic [TURN_W-1:0] turn;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch the input beat
        logic do_enq;   // push (or reject) and load result
        logic do_pop;   // read head of the winning ring, advance pointers
        logic do_empty; // load the both-empty result
        logic deliver;  // load the served result from read data
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_serve;
        logic any_avail;
        logic out_free;
    } dp_status_t;

endpackage

>>> src/tcspq_ctrl.sv
// Sequencing controller for the strict-priority queue scheduler.
// Depends on tcspq_pkg; drives tcspq_datapath through ctl_cmd_t.
module tcspq_ctrl
    import tcspq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t dp_status,
    output ctl_cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (dp_status.is_serve && dp_status.any_avail)
                begin
                    // read data is registered; the result loads in S_FETCH once the output register is free
                    cmd.do_pop = 1'b1;
                    state_next = S_FETCH;
                end
                else if (dp_status.is_serve && dp_status.out_free)
                begin
                    cmd.do_empty = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (!dp_status.is_serve && dp_status.out_free)
                begin
                    cmd.do_enq = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_FETCH:
            begin
                if (dp_status.out_free)
                begin
                    cmd.deliver = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/tcspq_datapath.sv
// Rings, pointers, turn counters and output register of the scheduler.
// Depends on tcspq_pkg; commanded by tcspq_ctrl.
module tcspq_datapath
    import tcspq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [KIND_W-1:0]   in_kind,
    input  logic [TAG_W-1:0]    in_tag,
    input  ctl_cmd_t            cmd,
    output dp_status_t          dp_status,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [STATUS_W-1:0] out_status,
    output logic [TURN_W-1:0]   out_turn,
    output logic [TAG_W-1:0]    out_tag
);

    localparam int SUM_W = CNT_W + 1;

    entry_t prio_mem [QUEUE_DEPTH];
    entry_t norm_mem [QUEUE_DEPTH];

    logic [KIND_W-1:0] kind_reg;
    logic [TAG_W-1:0]  tag_reg;

    logic [PTR_W-1:0]  prio_head_reg, prio_head_next;
    logic [CNT_W-1:0]  prio_count_reg, prio_count_next;
    logic [TURN_W-1:0] prio_turn_reg, prio_turn_next;
    logic [PTR_W-1:0]  norm_head_reg, norm_head_next;
    logic [CNT_W-1:0]  norm_count_reg, norm_count_next;
    logic [TURN_W-1:0] norm_turn_reg, norm_turn_next;

    logic              pop_prio_reg;
    entry_t            rd_data_reg;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [TURN_W-1:0] out_turn_reg, out_turn_next;
    logic [TAG_W-1:0]  out_tag_reg, out_tag_next;

    logic              sel_prio;
    logic              prio_full, norm_full, sel_full;
    logic              prio_avail, norm_avail;
    logic [SUM_W-1:0]  prio_sum, norm_sum;
    logic [PTR_W-1:0]  prio_tail, norm_tail;
    logic [PTR_W-1:0]  prio_head_inc, norm_head_inc;
    logic              load;
    logic              push_prio, push_norm;

    assign sel_prio   = !kind_reg[KIND_CLASS_BIT];
    assign prio_full  = (prio_count_reg == CNT_W'(QUEUE_DEPTH));
    assign norm_full  = (norm_count_reg == CNT_W'(QUEUE_DEPTH));
    assign sel_full   = sel_prio ? prio_full : norm_full;
    assign prio_avail = (prio_count_reg != '0);
    assign norm_avail = (norm_count_reg != '0);

    // tail = (head + count) mod depth; the sum stays below twice the depth
    assign prio_sum  = SUM_W'(prio_head_reg) + SUM_W'(prio_count_reg);
    assign norm_sum  = SUM_W'(norm_head_reg) + SUM_W'(norm_count_reg);
    assign prio_tail = (prio_sum >= SUM_W'(QUEUE_DEPTH))
                     ? PTR_W'(prio_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(prio_sum);
    assign norm_tail = (norm_sum >= SUM_W'(QUEUE_DEPTH))
                     ? PTR_W'(norm_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(norm_sum);

    assign prio_head_inc = (prio_head_reg == PTR_W'(QUEUE_DEPTH - 1))
                         ? '0 : prio_head_reg + 1'b1;
    assign norm_head_inc = (norm_head_reg == PTR_W'(QUEUE_DEPTH - 1))
                         ? '0 : norm_head_reg + 1'b1;

    assign push_prio = cmd.do_enq && sel_prio && !prio_full;
    assign push_norm = cmd.do_enq && !sel_prio && !norm_full;

    assign load = cmd.do_enq || cmd.do_empty || cmd.deliver;

    assign dp_status.is_serve  = kind_reg[KIND_SERVE_BIT];
    assign dp_status.any_avail = prio_avail || norm_avail;
    assign dp_status.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        prio_head_next  = prio_head_reg;
        prio_count_next = prio_count_reg;
        prio_turn_next  = prio_turn_reg;
        norm_head_next  = norm_head_reg;
        norm_count_next = norm_count_reg;
        norm_turn_next  = norm_turn_reg;

        if (push_prio)
        begin
            prio_count_next = prio_count_reg + 1'b1;
            prio_turn_next  = prio_turn_reg + 1'b1;
        end
        if (push_norm)
        begin
            norm_count_next = norm_count_reg + 1'b1;
            norm_turn_next  = norm_turn_reg + 1'b1;
        end
        if (cmd.do_pop)
        begin
            if (prio_avail)
            begin
                prio_head_next  = prio_head_inc;
                prio_count_next = prio_count_reg - 1'b1;
            end
            else
            begin
                norm_head_next  = norm_head_inc;
                norm_count_next = norm_count_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_turn_next   = out_turn_reg;
        out_tag_next    = out_tag_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        priority if (cmd.do_enq)
        begin
            out_tag_next = '0;
            if (sel_full)
            begin
                out_status_next = ST_FULL;
                out_turn_next   = '0;
            end
            else
            begin
                out_status_next = ST_ENQUEUED;
                out_turn_next   = sel_prio ? prio_turn_reg : norm_turn_reg;
            end
        end
        else if (cmd.do_empty)
        begin
            out_status_next = ST_EMPTY;
            out_turn_next   = '0;
            out_tag_next    = '0;
        end
        else if (cmd.deliver)
        begin
            out_status_next = pop_prio_reg ? ST_SERVED_PRIO : ST_SERVED_NORM;
            out_turn_next   = rd_data_reg.turn;
            out_tag_next    = rd_data_reg.tag;
        end
        else
        begin
            out_status_next = out_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_head_reg  <= '0;
            prio_count_reg <= '0;
            prio_turn_reg  <= TURN_W'(1);
            norm_head_reg  <= '0;
            norm_count_reg <= '0;
            norm_turn_reg  <= TURN_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prio_head_reg  <= prio_head_next;
            prio_count_reg <= prio_count_next;
            prio_turn_reg  <= prio_turn_next;
            norm_head_reg  <= norm_head_next;
            norm_count_reg <= norm_count_next;
            norm_turn_reg  <= norm_turn_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= in_kind;
            tag_reg  <= in_tag;
        end
        if (cmd.do_pop)
        begin
            pop_prio_reg <= prio_avail;
        end
        out_status_reg <= out_status_next;
        out_turn_reg   <= out_turn_next;
        out_tag_reg    <= out_tag_next;
    end

    // ring memories: one write port each, one registered read port shared by both
    always_ff @(posedge clk)
    begin
        if (push_prio)
        begin
            prio_mem[prio_tail] <= '{turn: prio_turn_reg, tag: tag_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_norm)
        begin
            norm_mem[norm_tail] <= '{turn: norm_turn_reg, tag: tag_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_pop)
        begin
            rd_data_reg <= prio_avail ? prio_mem[prio_head_reg] : norm_mem[norm_head_reg];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_turn   = out_turn_reg;
    assign out_tag    = out_tag_reg;

    ap_prio_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prio_count_reg <= CNT_W'(QUEUE_DEPTH) && norm_count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("ring count exceeds depth");

    ap_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_pop |-> (prio_avail || norm_avail))
        else $error("pop issued with both rings empty");

    ap_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

    ap_deliver_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_pop |=> !cmd.capture)
        else $error("new beat captured before served result delivered");

endmodule

>>> src/two_class_strict_priority_queue_top.sv
// Channel   | Dir | tvalid/tready       | Payload
// s         | in  | s_tvalid/s_tready   | tuser = kind[1:0]; tdata = tag[31:0]
// m         | out | m_tvalid/m_tready   | tuser = status[2:0]; tdata = turn, out_tag
//
// An enqueue is accepted, then pushed; a serve that finds an entry is accepted, then
// reads the ring into the registered read port, then loads the result, and a serve
// with both rings empty is accepted, then loads the empty result. Both rings share
// one read port. Results wait in an output register, so a new beat is accepted while
// one is held; completion waits until that register frees.
// rst_n clears pointers, counts and turn counters (to 1); ring contents are not reset.
// Top level: instantiates tcspq_ctrl and tcspq_datapath; depends on tcspq_pkg.
module two_class_strict_priority_queue_top
    import tcspq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] tag
    input  logic [1:0]  s_tuser,  // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // [15:0] turn, [47:16] out_tag
    output logic [2:0]  m_tuser   // [2:0] status
);

    ctl_cmd_t          cmd;
    dp_status_t        dp_status;
    logic [TURN_W-1:0] res_turn;
    logic [TAG_W-1:0]  res_tag;

    tcspq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    tcspq_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_kind    (s_tuser),
        .in_tag     (s_tdata),
        .cmd        (cmd),
        .dp_status  (dp_status),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_turn   (res_turn),
        .out_tag    (res_tag)
    );

    assign m_tdata = {res_tag, res_turn};

endmodule
